### rtl/weighted_gather_aggregator_top_defines.svh
// Assertion macros of the weighted gather aggregator top level.
`ifndef WEIGHTED_GATHER_AGGREGATOR_TOP_DEFINES_SVH
`define WEIGHTED_GATHER_AGGREGATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WGA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wga assertion failed");
`define WGA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wga assertion failed");
`else
`define WGA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define WGA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/wga_pkg.sv
// Types, constants and helper functions of the weighted gather aggregator.
package wga_pkg;

  localparam int MaxSources = 255;
  localparam int MaxShare   = 255;
  localparam int CntW       = $clog2(MaxSources + 1);
  localparam int InW        = 152;
  localparam int CfgIdxW    = 3;
  localparam int DivItW     = 7;
  localparam int CordSteps  = 24;
  localparam int CordIdxW   = $clog2(CordSteps);

  localparam logic [DivItW-1:0] DivWeightIters = DivItW'(17);
  localparam logic [DivItW-1:0] DivFullIters   = DivItW'(64);

  localparam logic [CfgIdxW-1:0] RegMetricMode   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFillValue    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegNanManyToOne = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegNanOneToMany = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegUseWeights   = CfgIdxW'(4);

  localparam logic signed [63:0] VsumLim = 64'sh007F_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] DsumLim = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic [40:0]        WsumLim = 41'h0FF_FFFF_FFFF;
  localparam logic signed [33:0] PiHalf  = 34'sd1686629713;

  typedef enum logic [1:0] {
    MODE_SUM   = 2'd0,
    MODE_MEAN  = 2'd1,
    MODE_COUNT = 2'd2,
    MODE_ANGLE = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] fill;
    logic               nmo;
    logic               otm;
    logic               use_w;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic wdiv_go;
    logic mul;
    logic acc;
    logic mdiv_go;
    logic norm_init;
    logic norm_step;
    logic dot_step;
    logic sqn_go;
    logic cdiv_go;
    logic c_latch;
    logic sqc_go;
    logic cord_init;
    logic cord_step;
    logic emit;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic  empty;
    logic  last;
    mode_t mode;
    logic  nan_now;
    logic  zero_wsum;
    logic  zero_vec;
    logic  div_done;
    logic  sq_done;
    logic  norm_ok;
    logic  dot_last;
    logic  cord_last;
    logic  out_free;
  } sts_t;

  function automatic logic signed [33:0] atan_q30(input logic [CordIdxW-1:0] i);
    case (i)
      5'd0:    atan_q30 = 34'sd843314857;
      5'd1:    atan_q30 = 34'sd497837829;
      5'd2:    atan_q30 = 34'sd263043837;
      5'd3:    atan_q30 = 34'sd133525159;
      5'd4:    atan_q30 = 34'sd67021687;
      5'd5:    atan_q30 = 34'sd33543516;
      5'd6:    atan_q30 = 34'sd16775851;
      5'd7:    atan_q30 = 34'sd8388437;
      5'd8:    atan_q30 = 34'sd4194283;
      5'd9:    atan_q30 = 34'sd2097149;
      5'd10:   atan_q30 = 34'sd1048576;
      5'd11:   atan_q30 = 34'sd524288;
      5'd12:   atan_q30 = 34'sd262144;
      5'd13:   atan_q30 = 34'sd131072;
      5'd14:   atan_q30 = 34'sd65536;
      5'd15:   atan_q30 = 34'sd32768;
      5'd16:   atan_q30 = 34'sd16384;
      5'd17:   atan_q30 = 34'sd8192;
      5'd18:   atan_q30 = 34'sd4096;
      5'd19:   atan_q30 = 34'sd2048;
      5'd20:   atan_q30 = 34'sd1024;
      5'd21:   atan_q30 = 34'sd512;
      5'd22:   atan_q30 = 34'sd256;
      5'd23:   atan_q30 = 34'sd128;
      default: atan_q30 = 34'sd0;
    endcase
  endfunction

  // Applies a sign to a magnitude and saturates to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    if (!neg) begin
      sat32 = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      sat32 = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
    end
  endfunction

endpackage

### rtl/wga_cfg.sv
// Configuration register file of the weighted gather aggregator.
module wga_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wga_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data,
  output wga_pkg::cfg_t                 cfg
);
  import wga_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegMetricMode:   cfg.mode  <= mode_t'(cfg_data[1:0]);
        RegFillValue:    cfg.fill  <= cfg_data;
        RegNanManyToOne: cfg.nmo   <= cfg_data[0];
        RegNanOneToMany: cfg.otm   <= cfg_data[0];
        RegUseWeights:   cfg.use_w <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/wga_div.sv
// Shared restoring divider, one quotient bit per cycle.
module wga_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [63:0]                 num,
  input  logic [39:0]                 den,
  input  logic [wga_pkg::DivItW-1:0]  iters,
  output logic [63:0]                 quo,
  output logic                        done
);
  import wga_pkg::*;

  logic [63:0]       n_q;
  logic [39:0]       rem;
  logic [39:0]       den_q;
  logic [DivItW-1:0] cnt;
  logic              busy;
  logic [40:0]       trial;
  logic              ge;

  assign trial = {rem, n_q[63]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !go && busy && cnt == DivItW'(1);
      if (go) begin
        busy <= 1'b1;
      end else if (busy && cnt == DivItW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      n_q   <= num;
      rem   <= '0;
      den_q <= den;
      quo   <= '0;
      cnt   <= iters;
    end else if (busy) begin
      rem <= ge ? 40'(trial - {1'b0, den_q}) : trial[39:0];
      n_q <= {n_q[62:0], 1'b0};
      quo <= {quo[62:0], ge};
      cnt <= cnt - DivItW'(1);
    end
  end

endmodule

### rtl/wga_dp.sv
// Datapath: accumulators, divider, square root, CORDIC and the output register.
module wga_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  wga_pkg::cfg_t             cfg,
  input  wga_pkg::cmd_t             cmd,
  output wga_pkg::sts_t             sts,
  input  logic [wga_pkg::InW-1:0]   in_data,
  input  logic                      in_empty,
  input  logic                      in_last,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [31:0]               out_data,
  output logic                      out_nan
);
  import wga_pkg::*;

  logic                     empty_q, last_q;
  logic signed [31:0]       val_q;
  logic [15:0]              wt_q;
  logic [7:0]               share_q;
  logic signed [15:0]       sd_q [3];
  logic signed [15:0]       td_q [3];

  logic signed [55:0]       vsum;
  logic [39:0]              wsum;
  logic [CntW-1:0]          cnt;
  logic signed [47:0]       dsum [3];
  logic                     nanp;

  logic signed [48:0]       pv;
  logic [15:0]              pw;
  logic signed [32:0]       ps [3];
  logic signed [31:0]       pd [3];

  logic [7:0]               share_e;
  logic [15:0]              e_w;
  logic [16:0]              wnum;
  logic [15:0]              w;
  logic signed [16:0]       w_s;

  logic                     div_go, div_done;
  logic [63:0]              div_num, div_quo;
  logic [39:0]              div_den;
  logic [DivItW-1:0]        div_iters;
  logic                     q_neg;

  logic [55:0]              vabs;
  logic [47:0]              mag [3];
  logic [47:0]              mx, mx_init;
  logic [47:0]              mabs [3];
  logic signed [45:0]       dot;
  logic [45:0]              dabs;
  logic [57:0]              n2;
  logic [1:0]               didx;
  logic [27:0]              mag_lo;
  logic signed [28:0]       m_sel;
  logic signed [44:0]       tm;

  logic [63:0]              sq_v, sq_r, sq_b, sq_in, sq_t;
  logic [4:0]               sq_cnt;
  logic                     sq_busy, sq_done, sq_go;

  logic signed [31:0]       c_q;
  logic [63:0]              csq;
  logic [30:0]              qc;

  logic signed [33:0]       cx, cy, ang, xs, ys, y_init;
  logic [CordIdxW-1:0]      ci;

  logic signed [33:0]       dts;
  logic [63:0]              srnd;
  logic [31:0]              sum_val, mean_val, cnt_val, ang_val, met_val;
  logic signed [33:0]       ang_r;
  logic                     nan_f;

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      empty_q  <= in_empty;
      last_q   <= in_last;
      val_q    <= in_data[31:0];
      wt_q     <= in_data[47:32];
      share_q  <= in_data[55:48];
      sd_q[0]  <= in_data[71:56];
      sd_q[1]  <= in_data[87:72];
      sd_q[2]  <= in_data[103:88];
      td_q[0]  <= in_data[119:104];
      td_q[1]  <= in_data[135:120];
      td_q[2]  <= in_data[151:136];
    end
  end

  // Implicit weight is rounded E over the share count.
  always_comb begin
    if (share_q == 8'd0) begin
      share_e = 8'd1;
    end else if (32'(share_q) > MaxShare) begin
      share_e = 8'(MaxShare);
    end else begin
      share_e = share_q;
    end
    e_w  = cfg.use_w ? wt_q : 16'd32768;
    wnum = {1'b0, e_w} + 17'(share_e >> 1);
    w    = div_quo[15:0];
    w_s  = $signed({1'b0, w});
  end

  assign vabs = vsum[55] ? 56'(-vsum) : 56'(vsum);
  assign dabs = dot[45] ? 46'(-dot) : 46'(dot);

  assign div_go = cmd.wdiv_go | cmd.mdiv_go | cmd.cdiv_go;

  always_comb begin
    if (cmd.wdiv_go) begin
      div_num   = {wnum, 47'b0};
      div_den   = 40'(share_e);
      div_iters = DivWeightIters;
    end else if (cmd.mdiv_go) begin
      div_num   = 64'(vabs) + 64'(wsum >> 1);
      div_den   = wsum;
      div_iters = DivFullIters;
    end else begin
      div_num   = {2'b0, dabs, 16'b0} + 64'(sq_r[29:1]);
      div_den   = 40'(sq_r[29:0]);
      div_iters = DivFullIters;
    end
  end

  wga_div u_div (
    .clk   (clk),
    .rst   (rst),
    .go    (div_go),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .quo   (div_quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.mdiv_go) begin
      q_neg <= vsum[55];
    end else if (cmd.cdiv_go) begin
      q_neg <= dot[45];
    end
  end

  // Products of one contribution.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pv <= val_q * w_s;
      pw <= w;
      for (int i = 0; i < 3; i++) begin
        ps[i] <= sd_q[i] * w_s;
        pd[i] <= td_q[i] * sd_q[i];
      end
    end
  end

  assign dts = 34'(pd[0]) + 34'(pd[1]) + 34'(pd[2]);

  // Group accumulators with saturation.
  always_ff @(posedge clk) begin
    logic signed [63:0] vs_n;
    logic [40:0]        ws_n;
    logic signed [33:0] term;
    logic signed [63:0] ds_n;
    if (rst || cmd.clr) begin
      vsum <= '0;
      wsum <= '0;
      cnt  <= '0;
      nanp <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        dsum[i] <= '0;
      end
    end else if (cmd.acc) begin
      if ((cfg.otm && share_e > 8'd1) || cnt >= CntW'(MaxSources)) begin
        nanp <= 1'b1;
      end
      if (cnt < CntW'(MaxSources)) begin
        cnt  <= cnt + CntW'(1);
        vs_n = 64'(vsum) + 64'(pv);
        if (vs_n > VsumLim) begin
          vsum <= 56'(VsumLim);
        end else if (vs_n < -VsumLim) begin
          vsum <= 56'(-VsumLim);
        end else begin
          vsum <= 56'(vs_n);
        end
        ws_n = 41'(wsum) + 41'(pw);
        wsum <= (ws_n > WsumLim) ? 40'(WsumLim) : 40'(ws_n);
        for (int i = 0; i < 3; i++) begin
          term = (dts < 0) ? -34'(ps[i]) : 34'(ps[i]);
          ds_n = 64'(dsum[i]) + 64'(term);
          if (ds_n > DsumLim) begin
            dsum[i] <= 48'(DsumLim);
          end else if (ds_n < -DsumLim) begin
            dsum[i] <= 48'(-DsumLim);
          end else begin
            dsum[i] <= 48'(ds_n);
          end
        end
      end
    end
  end

  // Mean direction normalization and dot product.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mabs[i] = dsum[i][47] ? 48'(-dsum[i]) : 48'(dsum[i]);
    end
    mx_init = mabs[0];
    if (mabs[1] > mx_init) mx_init = mabs[1];
    if (mabs[2] > mx_init) mx_init = mabs[2];
    mag_lo = mag[didx][27:0];
    m_sel  = dsum[didx][47] ? -$signed({1'b0, mag_lo}) : $signed({1'b0, mag_lo});
    tm     = td_q[didx] * m_sel;
  end

  always_ff @(posedge clk) begin
    if (cmd.norm_init) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= mabs[i];
      end
      mx   <= mx_init;
      dot  <= '0;
      n2   <= '0;
      didx <= '0;
    end else if (cmd.norm_step) begin
      if (mx[47:28] != '0) begin
        for (int i = 0; i < 3; i++) begin
          mag[i] <= mag[i] >> 1;
        end
        mx <= mx >> 1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          mag[i] <= mag[i] << 1;
        end
        mx <= mx << 1;
      end
    end else if (cmd.dot_step) begin
      dot  <= dot + 46'(tm);
      n2   <= n2 + 58'(mag_lo * mag_lo);
      didx <= didx + 2'd1;
    end
  end

  // Integer square root, two radicand bits per cycle.
  assign csq   = 64'(c_q * c_q);
  assign sq_go = cmd.sqn_go | cmd.sqc_go;
  assign sq_in = cmd.sqn_go ? 64'(n2) : (64'h1000_0000_0000_0000 - csq);
  assign sq_t  = sq_r + sq_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= !sq_go && sq_busy && sq_cnt == 5'd31;
      if (sq_go) begin
        sq_busy <= 1'b1;
      end else if (sq_busy && sq_cnt == 5'd31) begin
        sq_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_go) begin
      sq_v   <= sq_in;
      sq_r   <= '0;
      sq_b   <= 64'h4000_0000_0000_0000;
      sq_cnt <= '0;
    end else if (sq_busy) begin
      if (sq_v >= sq_t) begin
        sq_v <= sq_v - sq_t;
        sq_r <= (sq_r >> 1) + sq_b;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_b   <= sq_b >> 2;
      sq_cnt <= sq_cnt + 5'd1;
    end
  end

  // Cosine clamp and CORDIC vectoring.
  assign qc     = (div_quo > 64'h4000_0000) ? 31'h4000_0000 : div_quo[30:0];
  assign y_init = $signed({3'b0, sq_r[30:0]});
  assign xs     = cx >>> ci;
  assign ys     = cy >>> ci;

  always_ff @(posedge clk) begin
    if (cmd.c_latch) begin
      c_q <= q_neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    end
    if (cmd.cord_init) begin
      ci <= '0;
      if (c_q < 0) begin
        cx  <= y_init;
        cy  <= -34'(c_q);
        ang <= PiHalf;
      end else begin
        cx  <= 34'(c_q);
        cy  <= y_init;
        ang <= '0;
      end
    end else if (cmd.cord_step) begin
      ci <= ci + CordIdxW'(1);
      if (cy > 0) begin
        cx  <= cx + ys;
        cy  <= cy - xs;
        ang <= ang + atan_q30(ci);
      end else begin
        cx  <= cx - ys;
        cy  <= cy + xs;
        ang <= ang - atan_q30(ci);
      end
    end
  end

  // Final metric selection.
  always_comb begin
    srnd     = (64'(vabs) + 64'd16384) >> 15;
    sum_val  = sat32(vsum[55], srnd);
    mean_val = sat32(q_neg, div_quo);
    cnt_val  = 32'(cnt) << 16;
    ang_r    = (ang + 34'sd8192) >>> 14;
    ang_val  = (ang < 0) ? 32'd0 : 32'(ang_r);
    case (cfg.mode)
      MODE_SUM:   met_val = sum_val;
      MODE_MEAN:  met_val = mean_val;
      MODE_COUNT: met_val = cnt_val;
      MODE_ANGLE: met_val = ang_val;
      default:    met_val = sum_val;
    endcase
    nan_f = sts.nan_now || (cfg.mode == MODE_MEAN && sts.zero_wsum) ||
            (cfg.mode == MODE_ANGLE && sts.zero_vec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= empty_q ? cfg.fill : (nan_f ? 32'd0 : met_val);
      out_nan  <= !empty_q && nan_f;
    end
  end

  always_comb begin
    sts.empty     = empty_q;
    sts.last      = last_q;
    sts.mode      = cfg.mode;
    sts.nan_now   = nanp || (cfg.nmo && cnt > CntW'(1));
    sts.zero_wsum = wsum == '0;
    sts.zero_vec  = dsum[0] == '0 && dsum[1] == '0 && dsum[2] == '0;
    sts.div_done  = div_done;
    sts.sq_done   = sq_done;
    sts.norm_ok   = mx[47:28] == '0 && mx[27];
    sts.dot_last  = didx == 2'd2;
    sts.cord_last = ci == CordIdxW'(CordSteps - 1);
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

### rtl/wga_ctrl.sv
// Controller state machine that sequences the datapath for each beat.
module wga_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wga_pkg::sts_t  sts,
  output wga_pkg::cmd_t  cmd
);
  import wga_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CHK    = 16'h0002,
    S_WDIV   = 16'h0004,
    S_ACC    = 16'h0008,
    S_FIN    = 16'h0010,
    S_MDIV   = 16'h0020,
    S_NORM   = 16'h0040,
    S_DOT    = 16'h0080,
    S_SQNGO  = 16'h0100,
    S_SQN    = 16'h0200,
    S_CDIV   = 16'h0400,
    S_CLAT   = 16'h0800,
    S_SQCGO  = 16'h1000,
    S_SQC    = 16'h2000,
    S_CORD   = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.empty) begin
          state_next = S_DONE;
        end else begin
          cmd.wdiv_go = 1'b1;
          state_next  = S_WDIV;
        end
      end
      S_WDIV: begin
        if (sts.div_done) begin
          cmd.mul    = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (sts.nan_now) begin
          state_next = S_DONE;
        end else begin
          case (sts.mode)
            MODE_MEAN: begin
              if (sts.zero_wsum) begin
                state_next = S_DONE;
              end else begin
                cmd.mdiv_go = 1'b1;
                state_next  = S_MDIV;
              end
            end
            MODE_ANGLE: begin
              if (sts.zero_vec) begin
                state_next = S_DONE;
              end else begin
                cmd.norm_init = 1'b1;
                state_next    = S_NORM;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_MDIV: begin
        if (sts.div_done) state_next = S_DONE;
      end
      S_NORM: begin
        if (sts.norm_ok) begin
          state_next = S_DOT;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_DOT: begin
        cmd.dot_step = 1'b1;
        if (sts.dot_last) state_next = S_SQNGO;
      end
      S_SQNGO: begin
        cmd.sqn_go = 1'b1;
        state_next = S_SQN;
      end
      S_SQN: begin
        if (sts.sq_done) begin
          cmd.cdiv_go = 1'b1;
          state_next  = S_CDIV;
        end
      end
      S_CDIV: begin
        if (sts.div_done) state_next = S_CLAT;
      end
      S_CLAT: begin
        cmd.c_latch = 1'b1;
        state_next  = S_SQCGO;
      end
      S_SQCGO: begin
        cmd.sqc_go = 1'b1;
        state_next = S_SQC;
      end
      S_SQC: begin
        if (sts.sq_done) begin
          cmd.cord_init = 1'b1;
          state_next    = S_CORD;
        end
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.clr    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/weighted_gather_aggregator_top.sv
// Top level of the weighted gather aggregator.
//
//   channel   direction  beat carries
//   s_axis    in         one contribution or an empty-group marker
//   m_axis    out        one result per group
//   cfg       in         one register write
//
// A contribution beat waits on the 17-step weight divide. Closing a group adds a
// 64-step divide for mean, and for angle up to 27 normalize shifts, two
// 32-step square roots, a 64-step divide and 24 CORDIC steps.
// Reset is synchronous; it zeroes the registers and the group accumulators.
// A result waits in the output register while the next beat is taken; a group
// end stalls until that register is free.
`include "weighted_gather_aggregator_top_defines.svh"

module weighted_gather_aggregator_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // contrib_value, contrib_weight, share_count, source_dir_x, source_dir_y,
  // source_dir_z, target_dir_x, target_dir_y, target_dir_z
  input  logic [wga_pkg::InW-1:0]      s_axis_tdata,
  // empty_group
  input  logic                         s_axis_tuser,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // result_value
  output logic [31:0]                  m_axis_tdata,
  // result_nan
  output logic                         m_axis_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wga_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]                  cfg_data
);
  import wga_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  wga_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wga_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .in_empty  (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_nan   (m_axis_tuser)
  );

  `WGA_ASSERT_NEXT(a_one_beat_in_flight, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `WGA_ASSERT_SAME(a_result_from_work, clk, rst, $rose(m_axis_tvalid), $past(!s_axis_tready))
  `WGA_ASSERT_SAME(a_nan_zero_value, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)

endmodule
